FILE: hdl/sbs_pkg.sv
// Shared types and constants for the sparse bitset set-operation block.
// Used by every module of the block; depends on nothing.
package sbs_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int WORD_BITS  = 32;
  localparam int INDEX_BITS = 24;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POP_W      = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] MODE_UNION  = 3'd0;
  localparam logic [2:0] MODE_AND    = 3'd1;
  localparam logic [2:0] MODE_TEST   = 3'd2;
  localparam logic [2:0] MODE_XOR    = 3'd3;
  localparam logic [2:0] MODE_SUBSET = 3'd4;
  localparam logic [2:0] MODE_LESS   = 3'd5;

  localparam logic [1:0] REL_EQUAL    = 2'd0;
  localparam logic [1:0] REL_SUPERSET = 2'd1;
  localparam logic [1:0] REL_SUBSET   = 2'd2;
  localparam logic [1:0] REL_NEITHER  = 2'd3;

  typedef struct packed {
    logic                  list_select;
    logic [INDEX_BITS-1:0] word_index;
    logic [WORD_BITS-1:0]  word_bits;
    logic                  carries_fragment;
    logic                  end_of_list;
  } in_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] out_word_index;
    logic [WORD_BITS-1:0]  out_word_bits;
    logic                  has_fragment;
    logic [POP_W-1:0]      member_count;
    logic [1:0]            relation;
    logic                  flag;
    logic                  last_result;
  } out_t;

  typedef struct packed {
    logic                  wr;
    logic                  mrg;
    logic                  sel;
    logic [ADDR_W-1:0]     addr;
    logic [INDEX_BITS-1:0] idx;
    logic [WORD_BITS-1:0]  bits;
    logic [CNT_W-1:0]      na;
    logic [CNT_W-1:0]      nb;
    logic [2:0]            mode;
  } cmd_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic [WORD_BITS-1:0]  bits;
  } entry_t;

endpackage

FILE: hdl/sparse_bitset_set_operations.sv
// Top level of the sparse bitset set-operation block.
// Depends on sbs_pkg, sbs_front, sbs_cmd_fifo and sbs_merge.
//
// Usage: words enter as a queue (push / full), one per cycle while full
// is low. Each word adds a fragment to the first or second list or closes a
// list. When both lists are closed, a merge run under op_mode produces result
// words on a queue-like output (empty / pop); the final one of a run has
// last_result set. The user is to write op_mode through cfg_we_i / cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// Flow: a fragment word is written to its store at the edge where it leaves
// the four-entry command queue, which it enters when it is accepted. Each
// merge walk step is a registered store read, then a compare, as each of the
// two stores has a single read port; a run has up to na + nb steps between
// its start and finish states. Less-than and the summary modes take the same
// read-then-compare steps.
// The front keeps taking words into the command queue while a run is in
// progress or the receiver stalls; full rises only when that queue fills.
// Reset returns both lists to empty and op_mode to union; no clearing pass.
module sparse_bitset_set_operations (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_wdata_i,
  input  logic          push,
  output logic          full,
  input  sbs_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output sbs_pkg::out_t out_o
);

  logic          q_wr, q_full, q_rd, q_empty;
  sbs_pkg::cmd_t q_wcmd, q_rcmd;

  assign full = q_full;

  sbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_cmd_o     (q_wcmd)
  );

  sbs_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rcmd),
    .empty_o (q_empty)
  );

  sbs_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_rcmd),
    .q_rd_o    (q_rd),
    .out_o     (out_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

FILE: hdl/sbs_cmd_fifo.sv
// Short command queue between the front and the merge engine.
// Depends on sbs_pkg for the command type and depth.
module sbs_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  sbs_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output sbs_pkg::cmd_t rdata_o,
  output logic          empty_o
);

  sbs_pkg::cmd_t mem_q [sbs_pkg::QUEUE_DEPTH];
  logic [sbs_pkg::QPTR_W:0] wptr_q, rptr_q;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[sbs_pkg::QPTR_W] != rptr_q[sbs_pkg::QPTR_W]) &&
                   (wptr_q[sbs_pkg::QPTR_W-1:0] == rptr_q[sbs_pkg::QPTR_W-1:0]);
  assign rdata_o = mem_q[rptr_q[sbs_pkg::QPTR_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wptr_q[sbs_pkg::QPTR_W-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (wr_i && !full_o) wptr_q <= wptr_q + 1'b1;
      if (rd_i && !empty_o) rptr_q <= rptr_q + 1'b1;
    end
  end

endmodule

FILE: hdl/sbs_front.sv
// Front end: accepts input words, tracks list fill and closure, and issues
// store-write and merge commands. Depends on sbs_pkg.
module sbs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_wdata_i,
  input  logic          push_i,
  input  sbs_pkg::in_t  in_i,
  input  logic          q_full_i,
  output logic          q_wr_o,
  output sbs_pkg::cmd_t q_cmd_o
);

  logic [2:0] mode_q;
  logic [sbs_pkg::CNT_W-1:0] cnt_q [2];
  logic [sbs_pkg::CNT_W-1:0] cnt_sel, na, nb;
  logic [1:0] done_q;
  logic accept, open_list, wr, mrg;

  assign accept    = push_i && !q_full_i;
  assign open_list = !done_q[in_i.list_select];
  assign cnt_sel   = cnt_q[in_i.list_select];
  assign wr  = open_list && in_i.carries_fragment &&
               (cnt_sel < sbs_pkg::CNT_W'(sbs_pkg::LIST_DEPTH));
  assign mrg = open_list && in_i.end_of_list && done_q[!in_i.list_select];

  always_comb begin
    na = cnt_q[0];
    nb = cnt_q[1];
    if (wr && !in_i.list_select) na = cnt_q[0] + 1'b1;
    if (wr && in_i.list_select)  nb = cnt_q[1] + 1'b1;
  end

  assign q_wr_o = accept && (wr || mrg);
  always_comb begin
    q_cmd_o.wr   = wr;
    q_cmd_o.mrg  = mrg;
    q_cmd_o.sel  = in_i.list_select;
    q_cmd_o.addr = cnt_sel[sbs_pkg::ADDR_W-1:0];
    q_cmd_o.idx  = in_i.word_index;
    q_cmd_o.bits = in_i.word_bits;
    q_cmd_o.na   = na;
    q_cmd_o.nb   = nb;
    q_cmd_o.mode = mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sbs_pkg::MODE_UNION;
      cnt_q  <= '{default: '0};
      done_q <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (accept && open_list) begin
        if (mrg) begin
          cnt_q  <= '{default: '0};
          done_q <= '0;
        end else begin
          cnt_q[0] <= na;
          cnt_q[1] <= nb;
          if (in_i.end_of_list) done_q[in_i.list_select] <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/sbs_merge.sv
// Back end: holds both fragment stores and walks them under the selected
// mode, each merge step a store read and then a compare. Depends on sbs_pkg.
module sbs_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  sbs_pkg::cmd_t q_cmd_i,
  output logic          q_rd_o,
  output sbs_pkg::out_t out_o,
  output logic          empty_o,
  input  logic          pop_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  sbs_pkg::entry_t mem_a [sbs_pkg::LIST_DEPTH];
  sbs_pkg::entry_t mem_b [sbs_pkg::LIST_DEPTH];
  sbs_pkg::entry_t rd_a_q, rd_b_q;
  logic [sbs_pkg::ADDR_W-1:0] raddr_a, raddr_b;

  logic [sbs_pkg::CNT_W-1:0] i_q, i_d, j_q, j_d, na_q, nb_q;
  logic [2:0] mode_q;
  logic [sbs_pkg::POP_W-1:0] cnt_q, cnt_d;
  logic sup_q, sup_d, sub_q, sub_d, hit_q, hit_d, less_q, less_d;
  sbs_pkg::out_t pnd_q, pnd_d, out_q, out_d;
  logic pnd_valid_q, pnd_valid_d, out_valid_q, push;

  logic is_less, walk_more, va, vb, takea, takeb, emit, out_busy;
  logic [sbs_pkg::WORD_BITS-1:0] wa, wb, wres;
  logic [sbs_pkg::INDEX_BITS-1:0] widx;

  assign is_less   = (mode_q == sbs_pkg::MODE_LESS);
  assign raddr_a   = is_less ? i_q[sbs_pkg::ADDR_W-1:0] - 1'b1 : i_q[sbs_pkg::ADDR_W-1:0];
  assign raddr_b   = is_less ? j_q[sbs_pkg::ADDR_W-1:0] - 1'b1 : j_q[sbs_pkg::ADDR_W-1:0];
  assign q_rd_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign out_busy  = out_valid_q && !pop_i;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (q_rd_o && q_cmd_i.wr && !q_cmd_i.sel) mem_a[q_cmd_i.addr] <= {q_cmd_i.idx, q_cmd_i.bits};
    if (q_rd_o && q_cmd_i.wr && q_cmd_i.sel)  mem_b[q_cmd_i.addr] <= {q_cmd_i.idx, q_cmd_i.bits};
    rd_a_q <= mem_a[raddr_a];
    rd_b_q <= mem_b[raddr_b];
  end

  // One step of the ascending merge walk over both lists.
  always_comb begin
    va = (i_q < na_q);
    vb = (j_q < nb_q);
    if (va && vb) begin
      takea = (rd_a_q.idx <= rd_b_q.idx);
      takeb = (rd_b_q.idx <= rd_a_q.idx);
    end else begin
      takea = va;
      takeb = vb;
    end
    widx = takea ? rd_a_q.idx : rd_b_q.idx;
    wa   = takea ? rd_a_q.bits : '0;
    wb   = takeb ? rd_b_q.bits : '0;
    case (mode_q)
      sbs_pkg::MODE_UNION: begin
        emit = 1'b1;
        wres = wa | wb;
      end
      sbs_pkg::MODE_AND: begin
        emit = takea && takeb && ((wa & wb) != '0);
        wres = wa & wb;
      end
      sbs_pkg::MODE_XOR: begin
        emit = ((wa ^ wb) != '0) || !(takea && takeb);
        wres = wa ^ wb;
      end
      default: begin
        emit = 1'b0;
        wres = wa | wb;
      end
    endcase
  end

  assign walk_more = (i_q < na_q) || (j_q < nb_q);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    sup_d       = sup_q;
    sub_d       = sub_q;
    hit_d       = hit_q;
    less_d      = less_q;
    pnd_d       = pnd_q;
    pnd_valid_d = pnd_valid_q;
    push        = 1'b0;
    out_d       = pnd_q;
    case (state_q)
      ST_IDLE: begin
        if (q_rd_o && q_cmd_i.mrg) begin
          state_d     = (q_cmd_i.mode > sbs_pkg::MODE_LESS) ? ST_FIN : ST_RD;
          i_d         = (q_cmd_i.mode == sbs_pkg::MODE_LESS) ? q_cmd_i.na : '0;
          j_d         = (q_cmd_i.mode == sbs_pkg::MODE_LESS) ? q_cmd_i.nb : '0;
          cnt_d       = '0;
          sup_d       = 1'b1;
          sub_d       = 1'b1;
          hit_d       = 1'b0;
          less_d      = 1'b0;
          pnd_valid_d = 1'b0;
        end
      end
      ST_RD: begin
        if (is_less) begin
          if (i_q != '0 && j_q != '0) begin
            state_d = ST_CMP;
          end else begin
            less_d  = (j_q != '0);
            state_d = ST_FIN;
          end
        end else begin
          state_d = walk_more ? ST_CMP : ST_FIN;
        end
      end
      ST_CMP: begin
        if (is_less) begin
          if (rd_a_q.idx != rd_b_q.idx) begin
            less_d  = (rd_a_q.idx < rd_b_q.idx);
            state_d = ST_FIN;
          end else if (rd_a_q.bits != rd_b_q.bits) begin
            less_d  = (rd_a_q.bits < rd_b_q.bits);
            state_d = ST_FIN;
          end else begin
            i_d     = i_q - 1'b1;
            j_d     = j_q - 1'b1;
            state_d = ST_RD;
          end
        end else if (!(emit && pnd_valid_q && out_busy)) begin
          // A new fragment pushes the held one out; the held one waits so
          // that the final fragment can still be marked last.
          if (emit) begin
            push        = pnd_valid_q;
            pnd_valid_d = 1'b1;
            pnd_d       = '0;
            pnd_d.out_word_index = widx;
            pnd_d.out_word_bits  = wres;
            pnd_d.has_fragment   = 1'b1;
          end
          if (mode_q == sbs_pkg::MODE_UNION) begin
            cnt_d = cnt_q + sbs_pkg::POP_W'($countones(wres));
          end
          if (takea && takeb && ((wa & wb) != '0)) hit_d = 1'b1;
          if ((wa | wb) != wa) sup_d = 1'b0;
          if ((wa | wb) != wb) sub_d = 1'b0;
          i_d     = i_q + sbs_pkg::CNT_W'(takea);
          j_d     = j_q + sbs_pkg::CNT_W'(takeb);
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        if (!out_busy) begin
          push  = 1'b1;
          out_d = '0;
          case (mode_q)
            sbs_pkg::MODE_UNION, sbs_pkg::MODE_AND, sbs_pkg::MODE_XOR: begin
              if (pnd_valid_q) out_d = pnd_q;
              if (mode_q == sbs_pkg::MODE_UNION) out_d.member_count = cnt_q;
            end
            sbs_pkg::MODE_TEST: out_d.flag = hit_q;
            sbs_pkg::MODE_LESS: out_d.flag = less_q;
            sbs_pkg::MODE_SUBSET: begin
              out_d.relation = sup_q ? (sub_q ? sbs_pkg::REL_EQUAL : sbs_pkg::REL_SUPERSET)
                                     : (sub_q ? sbs_pkg::REL_SUBSET : sbs_pkg::REL_NEITHER);
            end
            default: out_d.flag = 1'b0;
          endcase
          out_d.last_result = 1'b1;
          pnd_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o && q_cmd_i.mrg) begin
      na_q   <= q_cmd_i.na;
      nb_q   <= q_cmd_i.nb;
      mode_q <= q_cmd_i.mode;
    end
    i_q    <= i_d;
    j_q    <= j_d;
    cnt_q  <= cnt_d;
    sup_q  <= sup_d;
    sub_q  <= sub_d;
    hit_q  <= hit_d;
    less_q <= less_d;
    pnd_q  <= pnd_d;
    if (push) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pnd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pnd_valid_q <= pnd_valid_d;
      if (push) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_held_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pnd_valid_q)
    else $error("held fragment left over after a run");
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CMP) && !is_less) |-> ((i_q <= na_q) && (j_q <= nb_q)))
    else $error("merge walk ran past a list end");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !out_busy)
    else $error("result overwritten before it was taken");
  a_fin_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && !out_busy) |=> (state_q == ST_IDLE) && out_valid_q
    && out_q.last_result)
    else $error("final result not delivered");
`endif

endmodule
